FILE: rtl/core/se3_log_velocity_core_assert.svh
// Assertion macros shared by the se3 log velocity core.
`ifndef SE3_LOG_VELOCITY_CORE_ASSERT_SVH
`define SE3_LOG_VELOCITY_CORE_ASSERT_SVH

// Same-cycle implication, reset masks the check.
`define S3LV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masks the check.
`define S3LV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/s3lv_pkg.sv
// Package with types, constants and helper functions of the se3 log velocity core.
`timescale 1ns / 1ps
`default_nettype none
package s3lv_pkg;

    localparam int CORDIC_STEPS_DEF = 32;
    localparam int QUEUE_DEPTH      = 2;
    localparam int DIV_W            = 64;

    localparam logic [30:0] THR_RESET = 31'd107374;

    localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;
    localparam logic signed [63:0] HALF_Q30    = 64'sd536870912;
    localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
    localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
    localparam logic signed [63:0] LIM         = 64'sh1000_0000_0000_0000;

    // Reciprocals ceil(2^59 / d). The multiplier drops 30 bits and a further shift
    // drops 29, which gives exact quotients for operands below 2^34.
    localparam int                 RECIP_SH = 29;
    localparam logic signed [63:0] RECIP_12 = 64'sd48038396025285291;
    localparam logic signed [63:0] RECIP_40 = 64'sd14411518807585588;
    localparam logic signed [63:0] RECIP_42 = 64'sd13725256007224369;
    localparam logic signed [63:0] RECIP_60 = 64'sd9607679205057059;

    localparam logic [1:0] ROW_LAST   = 2'd2;
    localparam logic [1:0] ROW_UNUSED = 2'd3;

    localparam logic signed [63:0] ATAN_TAB [11] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
        64'sd67021687, 64'sd33543516, 64'sd16775851, 64'sd8388437,
        64'sd4194283, 64'sd2097149, 64'sd1048576
    };

    typedef struct packed {
        logic [8:0][31:0] rot;
        logic [2:0][31:0] tr;
        logic [31:0]      dt;
    } t_job;

    typedef struct packed {
        logic busy;
        logic emitting;
    } t_back_status;

    typedef enum logic [4:0] {
        ST_IDLE, ST_TRACE, ST_CSQ, ST_SQRT, ST_CINIT, ST_CORDIC, ST_THETA,
        ST_T2, ST_SER, ST_FSER, ST_FDIV, ST_B40, ST_B42, ST_BM42, ST_B60,
        ST_BM60, ST_B12, ST_NUM, ST_RATIO, ST_BDIV, ST_W, ST_U, ST_V,
        ST_LIN, ST_OUT, ST_EMIT
    } t_state;

    function automatic logic signed [63:0] angle_step(input logic [5:0] idx);
        logic signed [63:0] r;
        if (idx < 6'd11) begin
            r = ATAN_TAB[idx[3:0]];
        end else if (idx <= 6'd30) begin
            r = 64'sd1 <<< (6'd30 - idx);
        end else begin
            r = '0;
        end
        return r;
    endfunction

    function automatic logic [1:0] mod3_next(input logic [1:0] k);
        return (k == 2'd2) ? 2'd0 : k + 2'd1;
    endfunction

    function automatic logic signed [63:0] sat_lim(input logic signed [63:0] v);
        logic signed [63:0] r;
        priority if (v > LIM) r = LIM;
        else if (v < -LIM) r = -LIM;
        else r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/s3lv_front.sv
// Front end: takes matrix rows, keeps rows 0 and 1, and queues a job on row 2.
`timescale 1ns / 1ps
`default_nettype none
module s3lv_front (
    input  logic           i_clk,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_row,
    input  logic [159:0]   i_data,
    input  logic           i_full,
    output logic           o_push,
    output s3lv_pkg::t_job o_job
);
    import s3lv_pkg::*;

    logic [31:0] r_rot [6];
    logic [31:0] r_tr  [2];
    logic        w_acc;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (w_acc && i_row != ROW_LAST && i_row != ROW_UNUSED) begin
            if (i_row[0]) begin
                r_rot[3] <= i_data[31:0];
                r_rot[4] <= i_data[63:32];
                r_rot[5] <= i_data[95:64];
            end else begin
                r_rot[0] <= i_data[31:0];
                r_rot[1] <= i_data[63:32];
                r_rot[2] <= i_data[95:64];
            end
            r_tr[i_row[0]] <= i_data[127:96];
        end
    end

    always_comb begin
        o_push = 1'b0;
        unique case (i_row)
            ROW_LAST: o_push = w_acc;
            default:  o_push = 1'b0;
        endcase
        for (int k = 0; k < 6; k++) o_job.rot[k] = r_rot[k];
        o_job.rot[6] = i_data[31:0];
        o_job.rot[7] = i_data[63:32];
        o_job.rot[8] = i_data[95:64];
        o_job.tr[0]  = r_tr[0];
        o_job.tr[1]  = r_tr[1];
        o_job.tr[2]  = i_data[127:96];
        o_job.dt     = i_data[159:128];
    end

endmodule
`default_nettype wire

FILE: rtl/core/s3lv_queue.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module s3lv_queue #(
    parameter int DEPTH = s3lv_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  s3lv_pkg::t_job i_job,
    input  logic           i_pop,
    output s3lv_pkg::t_job o_job,
    output logic           o_full,
    output logic           o_empty
);
    import s3lv_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/s3lv_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module s3lv_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [s3lv_pkg::DIV_W-1:0] i_num,
    input  logic [s3lv_pkg::DIV_W-1:0] i_den,
    output logic                       o_done,
    output logic [s3lv_pkg::DIV_W-1:0] o_quot
);
    import s3lv_pkg::*;

    localparam int NW = $clog2(DIV_W);

    logic             r_busy, r_done;
    logic [NW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_rem, r_quot, r_den;
    logic [DIV_W:0]   w_rem2;
    logic [DIV_W+1:0] w_diff;

    assign w_rem2 = {r_rem, r_quot[DIV_W-1]};
    assign w_diff = {1'b0, w_rem2} - {2'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!w_diff[DIV_W+1]) begin
                r_rem  <= w_diff[DIV_W-1:0];
                r_quot <= {r_quot[DIV_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem2[DIV_W-1:0];
                r_quot <= {r_quot[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == NW'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/s3lv_back.sv
// Back end: sequencer with square root, CORDIC, shared multiplier and divider.
`timescale 1ns / 1ps
`default_nettype none
module s3lv_back #(
    parameter int CORDIC_STEPS = s3lv_pkg::CORDIC_STEPS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_valid,
    input  s3lv_pkg::t_job         i_job,
    output logic                   o_pop,
    input  logic [30:0]            i_threshold,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [5:0][31:0]       o_vel,
    output logic                   o_status,
    output s3lv_pkg::t_back_status o_stat
);
    import s3lv_pkg::*;

    localparam int IW = $clog2(CORDIC_STEPS);

    t_state r_state, n_state;
    logic   r_issued;

    logic signed [31:0] r_rot [9];
    logic signed [31:0] r_tr  [3];
    logic [31:0]        r_dt;
    logic signed [31:0] r_c;
    logic [60:0]        r_sqn, r_sqres, r_sqbit;
    logic [30:0]        r_s;
    logic signed [63:0] r_x, r_y, r_z;
    logic [IW-1:0]      r_i;
    logic [31:0]        r_theta;
    logic [33:0]        r_t2;
    logic               r_series;
    logic signed [63:0] r_f, r_p, r_bq, r_tmp;
    logic [31:0]        r_num;
    logic [30:0]        r_ratio;
    logic signed [63:0] r_w [3];
    logic signed [63:0] r_u [3];
    logic signed [63:0] r_v [3];
    logic signed [63:0] r_lin [3];
    logic [2:0]         r_j;
    logic [5:0][31:0]   r_res;
    logic               r_ovalid, r_ostat;
    logic [5:0][31:0]   r_ovel;

    // Multiplier: four 32x32 partial products into a 128-bit accumulator.
    logic               m_start, r_mbusy, r_mdone, r_mneg;
    logic signed [63:0] m_a, m_b, m_res;
    logic [63:0]        r_mua, r_mub, m_mag, m_cap;
    logic [1:0]         r_mcnt;
    logic [127:0]       r_macc, m_sh;
    logic [63:0]        m_pp;

    logic               d_start, d_done;
    logic [63:0]        d_num, d_den, d_quot;

    logic signed [34:0] w_trsum, w_half;
    logic signed [63:0] w_cc, w_den, w_dx, w_dy, w_ang, w_mq;
    logic signed [32:0] w_d [3];
    logic [1:0]         w_k, w_k1, w_k2, w_ka, w_kb;
    logic [60:0]        w_rb;
    logic signed [63:0] w_oval;
    logic [63:0]        w_omag, w_olim;
    logic               w_osat, w_ozero, w_oskip, w_ostep;
    logic [31:0]        w_oq, w_ores;
    logic               w_emit, w_hard;

    s3lv_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d_start),
        .i_num   (d_num),
        .i_den   (d_den),
        .o_done  (d_done),
        .o_quot  (d_quot)
    );

    always_comb begin
        m_pp = 64'(r_mcnt[0] ? r_mua[63:32] : r_mua[31:0])
             * 64'(r_mcnt[1] ? r_mub[63:32] : r_mub[31:0]);
        unique case (r_mcnt)
            2'd0:       m_sh = {64'b0, m_pp};
            2'd1, 2'd2: m_sh = {32'b0, m_pp, 32'b0};
            default:    m_sh = {m_pp, 64'b0};
        endcase
        m_mag = r_macc[93:30];
        m_cap = (|r_macc[127:94] || m_mag > 64'(LIM)) ? 64'(LIM) : m_mag;
        m_res = r_mneg ? -$signed(m_cap) : $signed(m_cap);
    end

    always_ff @(posedge i_clk) begin
        if (m_start) begin
            r_mua  <= m_a[63] ? 64'(-m_a) : 64'(m_a);
            r_mub  <= m_b[63] ? 64'(-m_b) : 64'(m_b);
            r_mneg <= m_a[63] ^ m_b[63];
            r_macc <= '0;
        end else if (r_mbusy) begin
            r_macc <= r_macc + m_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
            r_mcnt  <= '0;
        end else begin
            r_mdone <= 1'b0;
            if (m_start) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= '0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + 1'b1;
                if (r_mcnt == 2'd3) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        w_trsum = 35'(r_rot[0]) + 35'(r_rot[4]) + 35'(r_rot[8]) - 35'sd1073741824;
        w_half  = w_trsum >>> 1;
        w_cc    = 64'(r_c) * 64'(r_c);
        w_rb    = r_sqres + r_sqbit;
        w_dx    = r_y >>> r_i;
        w_dy    = r_x >>> r_i;
        w_ang   = angle_step(6'(r_i));
        w_mq    = m_res >>> RECIP_SH;
        w_den   = (ONE_Q30 - 64'(r_c)) <<< 1;
        w_d[0]  = 33'(r_rot[7]) - 33'(r_rot[5]);
        w_d[1]  = 33'(r_rot[2]) - 33'(r_rot[6]);
        w_d[2]  = 33'(r_rot[3]) - 33'(r_rot[1]);
        w_k     = r_j[2:1];
        w_k1    = mod3_next(w_k);
        w_k2    = mod3_next(w_k1);
        w_ka    = r_j[0] ? w_k2 : w_k1;
        w_kb    = r_j[0] ? w_k1 : w_k2;
        w_oval  = (r_j < 3'd3) ? r_w[r_j[1:0]] : r_lin[2'(r_j - 3'd3)];
        w_omag  = w_oval[63] ? 64'(-w_oval) : 64'(w_oval);
        w_olim  = (r_j < 3'd3) ? {3'b0, r_dt, 29'b0} : {17'b0, r_dt, 15'b0};
        w_ozero = (w_omag == '0);
        w_osat  = (r_dt == '0) || (w_omag >= w_olim);
        w_oskip = !r_issued && (w_ozero || w_osat);
        w_ostep = w_oskip || d_done;
        w_oq    = w_oskip ? (w_ozero ? 32'd0 : 32'h8000_0000) : d_quot[31:0];
        w_ores  = w_oval[63] ? (~w_oq + 32'd1) : (w_oq[31] ? 32'h7FFF_FFFF : w_oq);
        w_emit  = (r_state == ST_EMIT) && (!r_ovalid || i_ready);
        w_hard  = !r_series && (w_den != '0) && (r_t2 != '0);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_job_valid) n_state = ST_TRACE;
            ST_TRACE:  n_state = ST_CSQ;
            ST_CSQ:    n_state = ST_SQRT;
            ST_SQRT:   if (r_sqbit[0]) n_state = ST_CINIT;
            ST_CINIT:  n_state = ST_CORDIC;
            ST_CORDIC: if (r_i == IW'(CORDIC_STEPS - 1)) n_state = ST_THETA;
            ST_THETA:  n_state = ST_T2;
            ST_T2:     if (r_mdone) n_state = ST_SER;
            ST_SER: begin
                priority if ({1'b0, r_theta} <= {2'b0, i_threshold}) n_state = ST_FSER;
                else if (r_s == '0) n_state = ST_B40;
                else n_state = ST_FDIV;
            end
            ST_FSER:   if (r_mdone) n_state = ST_B40;
            ST_FDIV:   if (d_done) n_state = ST_B40;
            ST_B40:    if (r_mdone) n_state = ST_B42;
            ST_B42:    if (r_mdone) n_state = ST_BM42;
            ST_BM42:   if (r_mdone) n_state = ST_B60;
            ST_B60:    if (r_mdone) n_state = ST_BM60;
            ST_BM60:   if (r_mdone) n_state = ST_B12;
            ST_B12:    if (r_mdone) n_state = w_hard ? ST_NUM : ST_W;
            ST_NUM:    if (r_mdone) n_state = ST_RATIO;
            ST_RATIO:  if (d_done) n_state = ST_BDIV;
            ST_BDIV:   if (d_done) n_state = ST_W;
            ST_W:      if (r_mdone && r_j == 3'd2) n_state = ST_U;
            ST_U:      if (r_mdone && r_j == 3'd5) n_state = ST_V;
            ST_V:      if (r_mdone && r_j == 3'd5) n_state = ST_LIN;
            ST_LIN:    if (r_mdone && r_j == 3'd5) n_state = ST_OUT;
            ST_OUT:    if (w_ostep && r_j == 3'd5) n_state = ST_EMIT;
            ST_EMIT:   if (w_emit) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        m_start = 1'b0;
        m_a     = '0;
        m_b     = '0;
        d_start = 1'b0;
        d_num   = '0;
        d_den   = '0;
        unique case (r_state)
            ST_T2: begin
                m_a = 64'(r_theta);
                m_b = 64'(r_theta);
            end
            ST_FSER: begin
                m_a = 64'(r_t2);
                m_b = RECIP_12;
            end
            ST_B40: begin
                m_a = 64'(r_t2);
                m_b = RECIP_40;
            end
            ST_B42: begin
                m_a = 64'(r_t2);
                m_b = RECIP_42;
            end
            ST_B60: begin
                m_a = 64'(r_t2);
                m_b = RECIP_60;
            end
            ST_B12: begin
                m_a = r_p;
                m_b = RECIP_12;
            end
            ST_BM42, ST_BM60: begin
                m_a = r_tmp;
                m_b = r_p;
            end
            ST_NUM: begin
                m_a = 64'(r_theta);
                m_b = 64'(r_s);
            end
            ST_W: begin
                m_a = r_f;
                m_b = 64'(w_d[r_j[1:0]]);
            end
            ST_U: begin
                m_a = r_w[w_ka];
                m_b = 64'(r_tr[w_kb]);
            end
            ST_V: begin
                m_a = r_w[w_ka];
                m_b = r_u[w_kb];
            end
            ST_LIN: begin
                m_a = r_j[0] ? r_bq : r_u[w_k];
                m_b = r_j[0] ? r_v[w_k] : HALF_Q30;
            end
            ST_FDIV: begin
                d_num = {r_theta, 30'b0, 2'b0} >> 2;
                d_den = 64'({r_s, 1'b0});
            end
            ST_RATIO: begin
                d_num = {2'b0, r_num, 30'b0};
                d_den = 64'(w_den);
            end
            ST_BDIV: begin
                d_num = {3'b0, 31'(ONE_Q30) - r_ratio, 30'b0};
                d_den = 64'(r_t2);
            end
            ST_OUT: begin
                d_num = (r_j < 3'd3) ? {w_omag[61:0], 2'b0} : {w_omag[47:0], 16'b0};
                d_den = 64'(r_dt);
            end
            default: ;
        endcase
        unique case (r_state)
            ST_T2, ST_FSER, ST_B40, ST_B42, ST_BM42, ST_B60, ST_BM60, ST_B12,
            ST_NUM, ST_W, ST_U, ST_V, ST_LIN:
                m_start = !r_issued;
            ST_FDIV, ST_RATIO, ST_BDIV:
                d_start = !r_issued;
            ST_OUT: d_start = !r_issued && !w_oskip;
            default: ;
        endcase
        o_pop         = (r_state == ST_IDLE) && i_job_valid;
        o_stat.busy     = (r_state != ST_IDLE);
        o_stat.emitting = w_emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_mdone || d_done) r_issued <= 1'b0;
            else if (m_start || d_start) r_issued <= 1'b1;
            if (w_emit) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_ovel  <= r_res;
            r_ostat <= (PI_Q30 - 64'(r_theta)) <= 64'(i_threshold);
        end
        unique case (r_state)
            ST_IDLE: begin
                for (int k = 0; k < 9; k++) r_rot[k] <= $signed(i_job.rot[k]);
                for (int k = 0; k < 3; k++) r_tr[k] <= $signed(i_job.tr[k]);
                r_dt <= i_job.dt;
            end
            ST_TRACE: begin
                priority if (w_half > 35'sd1073741824) r_c <= 32'sd1073741824;
                else if (w_half < -35'sd1073741824) r_c <= -32'sd1073741824;
                else r_c <= 32'(w_half);
                r_j <= '0;
            end
            ST_CSQ: begin
                r_sqn   <= 61'((64'sd1 <<< 60) - w_cc);
                r_sqres <= '0;
                r_sqbit <= 61'(1) << 60;
            end
            ST_SQRT: begin
                if (r_sqn >= w_rb) begin
                    r_sqn   <= r_sqn - w_rb;
                    r_sqres <= (r_sqres >> 1) + r_sqbit;
                end else begin
                    r_sqres <= r_sqres >> 1;
                end
                r_sqbit <= r_sqbit >> 2;
            end
            ST_CINIT: begin
                r_s <= r_sqres[30:0];
                r_i <= '0;
                if (r_c[31]) begin
                    r_x <= 64'(r_sqres[30:0]);
                    r_y <= -64'(r_c);
                    r_z <= HALF_PI_Q30;
                end else begin
                    r_x <= 64'(r_c);
                    r_y <= 64'(r_sqres[30:0]);
                    r_z <= '0;
                end
            end
            ST_CORDIC: begin
                r_i <= r_i + 1'b1;
                if (!r_y[63]) begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_ang;
                end else begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_ang;
                end
            end
            ST_THETA: begin
                priority if (r_z[63]) r_theta <= '0;
                else if (r_z > PI_Q30) r_theta <= 32'(PI_Q30);
                else r_theta <= 32'(r_z);
            end
            ST_T2:    if (r_mdone) r_t2 <= 34'(m_res);
            ST_SER: begin
                r_series <= {1'b0, r_theta} <= {2'b0, i_threshold};
                if (r_s == '0) r_f <= LIM;
            end
            ST_FSER:  if (r_mdone) r_f <= HALF_Q30 + w_mq;
            ST_FDIV:  if (d_done) r_f <= (d_quot > 64'(LIM)) ? LIM : $signed(d_quot);
            ST_B40:   if (r_mdone) r_p <= ONE_Q30 + w_mq;
            ST_B42, ST_B60: if (r_mdone) r_tmp <= w_mq;
            ST_BM42, ST_BM60: if (r_mdone) r_p <= ONE_Q30 + m_res;
            ST_B12:   if (r_mdone) r_bq <= w_mq;
            ST_NUM:   if (r_mdone) r_num <= 32'(m_res);
            ST_RATIO: if (d_done) r_ratio <= (d_quot > 64'(ONE_Q30)) ? 31'(ONE_Q30)
                                                                    : 31'(d_quot);
            ST_BDIV:  if (d_done) r_bq <= (d_quot > 64'(LIM)) ? LIM : $signed(d_quot);
            ST_W: begin
                if (r_mdone) begin
                    r_w[r_j[1:0]] <= m_res;
                    r_j <= (r_j == 3'd2) ? 3'd0 : r_j + 3'd1;
                end
            end
            ST_U, ST_V, ST_LIN: begin
                if (r_mdone) begin
                    r_j <= (r_j == 3'd5) ? 3'd0 : r_j + 3'd1;
                    if (!r_j[0]) begin
                        r_tmp <= m_res;
                    end else if (r_state == ST_U) begin
                        r_u[w_k] <= sat_lim(r_tmp - m_res);
                    end else if (r_state == ST_V) begin
                        r_v[w_k] <= sat_lim(r_tmp - m_res);
                    end else begin
                        r_lin[w_k] <= sat_lim(64'(r_tr[w_k]) - r_tmp + m_res);
                    end
                end
            end
            ST_OUT: begin
                if (w_ostep) begin
                    r_res[r_j] <= w_ores;
                    r_j <= (r_j == 3'd5) ? 3'd0 : r_j + 3'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_valid  = r_ovalid;
    assign o_vel    = r_ovel;
    assign o_status = r_ostat;

endmodule
`default_nettype wire

FILE: rtl/core/se3_log_velocity_core.sv
// Top level of the se3 log velocity core.
//
// Usage: send the top three rows of a rigid transform on the s_axis channel,
// one transfer per row. tuser carries the row index; tdata carries the three
// rotation entries (Q2.30), the translation entry (Q16.16) and, used with row
// 2, the elapsed time (Q16.16 seconds). Row index 3 is dropped.
// Rows 0 and 1 are stored in registers and give no result. Row 2 queues a job
// and yields one m_axis transfer: angular and linear velocities (Q16.16,
// saturated) in tdata and the near-pi flag in tuser.
// One job is worked on at a time: a 31-step square root, CORDIC_STEPS CORDIC
// steps, up to 29 multiplies (constant divisions are reciprocal multiplies)
// and up to nine divisions on a one-bit-per-cycle divider. A two-job queue
// decouples the front end, so up to two row 2 transfers can wait while one
// result is computed. A stalled receiver holds the result in the output
// register; the back end keeps working and waits only to emit. Reset clears
// the control state; near_zero_threshold returns to 107374. The user writes
// the threshold through i_cfg_we and i_cfg_wdata only while idle; the core
// itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module se3_log_velocity_core #(
    parameter int CORDIC_STEPS = s3lv_pkg::CORDIC_STEPS_DEF,
    parameter int QUEUE_DEPTH  = s3lv_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [30:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // rotation_col0, rotation_col1, rotation_col2, translation, elapsed_time
    input  logic [159:0] s_axis_tdata,
    // row_index
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // angular_vel_x, _y, _z, linear_vel_x, _y, _z
    output logic [191:0] m_axis_tdata,
    // status
    output logic [0:0]   m_axis_tuser
);
    import s3lv_pkg::*;

    `include "se3_log_velocity_core_assert.svh"

    logic [30:0]    r_thr;
    logic           w_push, w_pop, w_qfull, w_qempty, w_status;
    t_job           w_fjob, w_qjob;
    t_back_status   w_bstat;
    logic [5:0][31:0] w_vel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    s3lv_front u_front (
        .i_clk   (i_clk),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_row   (s_axis_tuser),
        .i_data  (s_axis_tdata),
        .i_full  (w_qfull),
        .o_push  (w_push),
        .o_job   (w_fjob)
    );

    s3lv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_job   (w_qjob),
        .o_full  (w_qfull),
        .o_empty (w_qempty)
    );

    s3lv_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_qempty),
        .i_job       (w_qjob),
        .o_pop       (w_pop),
        .i_threshold (r_thr),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_vel       (w_vel),
        .o_status    (w_status),
        .o_stat      (w_bstat)
    );

    assign m_axis_tdata = w_vel;
    assign m_axis_tuser = w_status;

    `S3LV_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, w_push, !w_qfull || w_pop, "job pushed into a full queue")
    `S3LV_ASSERT_IMPL(a_out_from_emit, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(w_bstat.emitting), "result shown without an emit")
    `S3LV_ASSERT_NEXT(a_pop_busy, i_clk, i_rst_n, w_pop, w_bstat.busy, "back end idle after taking a job")
    `S3LV_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, w_pop, !w_qempty, "pop from an empty queue")

endmodule
`default_nettype wire
